// File: design/utps_pkg.sv
// Shared types and constants of the USB transaction packet splitter.
`default_nettype none

package utps_pkg;

    localparam int LEN_W   = 12;
    localparam int ADDR_W  = 32;
    localparam int MPS_W   = 10;
    localparam int KIND_W  = 2;
    localparam int PID_W   = 2;
    localparam int DEFAULT_MAX_PACKETS = 64;
    localparam logic [MPS_W-1:0] MPS_RESET = MPS_W'(64);

    // Packet identifiers
    localparam logic [PID_W-1:0] PID_SETUP = 2'd0;
    localparam logic [PID_W-1:0] PID_IN    = 2'd1;
    localparam logic [PID_W-1:0] PID_OUT   = 2'd2;

    // Transfer kinds
    localparam logic [KIND_W-1:0] KIND_CONTROL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BULK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INTR    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ISO     = 2'd3;

    // Register indexes
    localparam logic REG_MPS  = 1'b0;
    localparam logic REG_KIND = 1'b1;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic              setup;
        logic              err;
        logic              handshake;
        logic              add_empty;
        logic [LEN_W-1:0]  ndata;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
    } desc_t;

endpackage

`default_nettype wire

// File: design/utps_front.sv
// Front end: accepts transactions, counts data packets and classifies them.
`default_nettype none

module utps_front #(
    parameter int MAX_PACKETS = utps_pkg::DEFAULT_MAX_PACKETS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_func,
    input  wire logic [utps_pkg::LEN_W-1:0]  s_byte_length,
    input  wire logic [utps_pkg::ADDR_W-1:0] s_base_address,
    input  wire logic                        s_want_empty_packet,
    input  wire logic                        s_force_toggle_one,
    input  wire logic [utps_pkg::MPS_W-1:0]  mps,
    input  wire logic [utps_pkg::KIND_W-1:0] kind,
    output logic                             q_wr_en,
    output utps_pkg::desc_t                  q_wr_data,
    input  wire logic                        q_full
);

    localparam int LEN_W = utps_pkg::LEN_W;
    localparam int MPS_W = utps_pkg::MPS_W;
    localparam int CNT_W = $clog2(LEN_W);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [MPS_W-1:0]              rem_reg, rem_next;
    logic [LEN_W-1:0]              quo_reg, quo_next;
    logic [MPS_W-1:0]              div_reg;
    logic [utps_pkg::PID_W-1:0]    pid_reg;
    logic [LEN_W-1:0]              len_reg;
    logic [utps_pkg::ADDR_W-1:0]   base_reg;
    logic                          we_reg;
    logic                          hs_reg;

    logic [MPS_W:0]  trial;
    logic            ge;
    logic            setup;
    logic [LEN_W-1:0] ndata;
    logic            add_empty;
    logic            nothing;

    assign s_ready = (state_reg == F_IDLE);

    // One quotient bit per cycle
    assign trial = {rem_reg, quo_reg[LEN_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});

    assign setup = (pid_reg == utps_pkg::PID_SETUP);

    always_comb begin
        if (setup) begin
            ndata = LEN_W'(len_reg != '0);
        end else begin
            ndata = quo_reg + LEN_W'(rem_reg != '0);
        end
        add_empty = we_reg ||
                    (kind == utps_pkg::KIND_BULK && pid_reg == utps_pkg::PID_OUT &&
                     len_reg != '0 && rem_reg == '0);
        nothing = (ndata == '0) && !add_empty;
    end

    always_comb begin
        q_wr_data.pid       = pid_reg;
        q_wr_data.setup     = setup;
        q_wr_data.err       = (ndata > LEN_W'(MAX_PACKETS - 1));
        q_wr_data.handshake = hs_reg;
        q_wr_data.add_empty = add_empty;
        q_wr_data.ndata     = ndata;
        q_wr_data.len       = len_reg;
        q_wr_data.base      = base_reg;
        q_wr_en = (state_reg == F_PUSH) && !nothing && !q_full;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                    quo_next   = s_byte_length;
                end
            end
            F_DIV: begin
                rem_next = ge ? MPS_W'(trial - {1'b0, div_reg}) : MPS_W'(trial);
                quo_next = {quo_reg[LEN_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LEN_W - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                // drop a transaction with nothing to send
                if (nothing || !q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (s_valid && s_ready) begin
            div_reg  <= (mps == '0) ? MPS_W'(1) : mps;
            pid_reg  <= (s_func == 2'd0) ? utps_pkg::PID_SETUP :
                        (s_func == 2'd1) ? utps_pkg::PID_IN : utps_pkg::PID_OUT;
            len_reg  <= s_byte_length;
            base_reg <= s_base_address;
            we_reg   <= s_want_empty_packet;
            hs_reg   <= s_force_toggle_one;
        end
    end

endmodule

`default_nettype wire

// File: design/utps_queue.sv
// Two-entry queue of classified transactions between front and back.
`default_nettype none

module utps_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_en,
    input  wire utps_pkg::desc_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output utps_pkg::desc_t      rd_data,
    output logic                 empty
);

    utps_pkg::desc_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/utps_back.sv
// Back end: walks a classified transaction and emits its packet beats.
`default_nettype none

module utps_back #(
    parameter int MAX_PACKETS = utps_pkg::DEFAULT_MAX_PACKETS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire utps_pkg::desc_t             q_rd_data,
    input  wire logic                        q_empty,
    output logic                             q_rd_en,
    input  wire logic [utps_pkg::MPS_W-1:0]  mps,
    input  wire logic [utps_pkg::KIND_W-1:0] kind,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [utps_pkg::PID_W-1:0]       m_packet_id,
    output logic                             m_data_toggle,
    output logic [utps_pkg::LEN_W-1:0]       m_packet_bytes,
    output logic [utps_pkg::ADDR_W-1:0]      m_packet_address,
    output logic                             m_final_packet,
    output logic                             m_too_long
);

    localparam int LEN_W  = utps_pkg::LEN_W;
    localparam int ADDR_W = utps_pkg::ADDR_W;
    localparam int CNT_W  = $clog2(MAX_PACKETS);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_LOAD = 2'd1;
    localparam logic [1:0] B_RUN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    utps_pkg::desc_t   ent_reg;
    logic              tog_reg, tog_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              empty_reg, empty_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic              m_valid_reg, m_valid_next;
    logic [utps_pkg::PID_W-1:0] pid_reg, pid_next;
    logic              otog_reg, otog_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic [ADDR_W-1:0] oaddr_reg, oaddr_next;
    logic              fin_reg, fin_next;
    logic              err_reg, err_next;

    logic              iso;
    logic              out_free;
    logic [LEN_W-1:0]  mps_eff;
    logic [LEN_W-1:0]  step;
    logic              tog;

    assign iso      = (kind == utps_pkg::KIND_ISO);
    assign out_free = !m_valid_reg || m_ready;
    assign mps_eff  = (mps == '0) ? LEN_W'(1) : LEN_W'(mps);
    assign q_rd_en  = (state_reg == B_IDLE) && !q_empty;

    always_comb begin
        if (left_reg == '0) begin
            step = '0;
        end else if (ent_reg.setup) begin
            step = remain_reg;
        end else begin
            step = (remain_reg < mps_eff) ? remain_reg : mps_eff;
        end
        tog = (ent_reg.setup || iso) ? 1'b0 : tog_reg;
    end

    always_comb begin
        state_next   = state_reg;
        tog_next     = tog_reg;
        left_next    = left_reg;
        empty_next   = empty_reg;
        remain_next  = remain_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pid_next     = pid_reg;
        otog_next    = otog_reg;
        bytes_next   = bytes_reg;
        oaddr_next   = oaddr_reg;
        fin_next     = fin_reg;
        err_next     = err_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = B_LOAD;
                end
            end
            B_LOAD: begin
                if (ent_reg.err) begin
                    // single error beat, toggle left alone
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        pid_next     = ent_reg.pid;
                        otog_next    = 1'b0;
                        bytes_next   = '0;
                        oaddr_next   = ent_reg.base;
                        fin_next     = 1'b1;
                        err_next     = 1'b1;
                        state_next   = B_IDLE;
                    end
                end else begin
                    if (ent_reg.handshake && !iso) begin
                        tog_next = 1'b1;
                    end
                    left_next   = ent_reg.ndata[CNT_W-1:0];
                    empty_next  = ent_reg.add_empty;
                    remain_next = ent_reg.len;
                    addr_next   = ent_reg.base;
                    state_next  = B_RUN;
                end
            end
            B_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    pid_next     = ent_reg.pid;
                    otog_next    = tog;
                    bytes_next   = step;
                    oaddr_next   = addr_reg;
                    err_next     = 1'b0;
                    if (!iso) begin
                        tog_next = ~tog;
                    end
                    remain_next = remain_reg - step;
                    addr_next   = addr_reg + ADDR_W'(step);
                    if (left_reg != '0) begin
                        left_next = left_reg - 1'b1;
                        fin_next  = (left_reg == CNT_W'(1)) && !empty_reg;
                    end else begin
                        empty_next = 1'b0;
                        fin_next   = 1'b1;
                    end
                    if ((left_reg == CNT_W'(1) && !empty_reg) || left_reg == '0) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            tog_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tog_reg     <= tog_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_rd_en) begin
            ent_reg <= q_rd_data;
        end
        left_reg   <= left_next;
        empty_reg  <= empty_next;
        remain_reg <= remain_next;
        addr_reg   <= addr_next;
        pid_reg    <= pid_next;
        otog_reg   <= otog_next;
        bytes_reg  <= bytes_next;
        oaddr_reg  <= oaddr_next;
        fin_reg    <= fin_next;
        err_reg    <= err_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_packet_id      = pid_reg;
    assign m_data_toggle    = otog_reg;
    assign m_packet_bytes   = bytes_reg;
    assign m_packet_address = oaddr_reg;
    assign m_final_packet   = fin_reg;
    assign m_too_long       = err_reg;

endmodule

`default_nettype wire

// File: design/usb_transaction_packet_splitter.sv
// Top level of the USB transaction packet splitter with its register port.
//
// Each accepted transaction is turned into its packet descriptors, one beat per
// packet in bus order. In the front end a restoring divider works out the packet
// count one quotient bit per cycle over the 12-bit length, then the transaction
// is classified and queued. The back end loads a queued transaction and then
// emits one beat per cycle while the result side is ready. A two-entry queue
// sits between the two halves, and the result side has its own output register.
// Registers: max_packet_size at 0x0, transfer_kind at 0x4; write them only
// while no transaction is in flight.
`default_nettype none

module usb_transaction_packet_splitter #(
    parameter int MAX_PACKETS = utps_pkg::DEFAULT_MAX_PACKETS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_func,
    input  wire logic [utps_pkg::LEN_W-1:0]  s_byte_length,
    input  wire logic [utps_pkg::ADDR_W-1:0] s_base_address,
    input  wire logic                        s_want_empty_packet,
    input  wire logic                        s_force_toggle_one,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [utps_pkg::PID_W-1:0]       m_packet_id,
    output logic                             m_data_toggle,
    output logic [utps_pkg::LEN_W-1:0]       m_packet_bytes,
    output logic [utps_pkg::ADDR_W-1:0]      m_packet_address,
    output logic                             m_final_packet,
    output logic                             m_too_long
);

    localparam int MPS_W  = utps_pkg::MPS_W;
    localparam int KIND_W = utps_pkg::KIND_W;

    logic [MPS_W-1:0]  mps_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              cfg_wr;

    logic              q_wr_en;
    utps_pkg::desc_t   q_wr_data;
    logic              q_full;
    logic              q_rd_en;
    utps_pkg::desc_t   q_rd_data;
    logic              q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mps_reg  <= utps_pkg::MPS_RESET;
            kind_reg <= utps_pkg::KIND_CONTROL;
        end else if (cfg_wr) begin
            case (paddr[2])
                utps_pkg::REG_MPS:  mps_reg  <= pwdata[MPS_W-1:0];
                utps_pkg::REG_KIND: kind_reg <= pwdata[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            utps_pkg::REG_MPS:  prdata = {{(32 - MPS_W){1'b0}}, mps_reg};
            utps_pkg::REG_KIND: prdata = {{(32 - KIND_W){1'b0}}, kind_reg};
            default:            prdata = '0;
        endcase
    end

    utps_front #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_byte_length       (s_byte_length),
        .s_base_address      (s_base_address),
        .s_want_empty_packet (s_want_empty_packet),
        .s_force_toggle_one  (s_force_toggle_one),
        .mps                 (mps_reg),
        .kind                (kind_reg),
        .q_wr_en             (q_wr_en),
        .q_wr_data           (q_wr_data),
        .q_full              (q_full)
    );

    utps_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    utps_back #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_rd_data        (q_rd_data),
        .q_empty          (q_empty),
        .q_rd_en          (q_rd_en),
        .mps              (mps_reg),
        .kind             (kind_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_id      (m_packet_id),
        .m_data_toggle    (m_data_toggle),
        .m_packet_bytes   (m_packet_bytes),
        .m_packet_address (m_packet_address),
        .m_final_packet   (m_final_packet),
        .m_too_long       (m_too_long)
    );

endmodule

`default_nettype wire

// File: verif/usb_transaction_packet_splitter_test.sv
// Self-checking testbench for the USB transaction packet splitter.
`timescale 1ns / 1ps

module usb_transaction_packet_splitter_test;

    import utps_pkg::*;

    localparam int PKT_LIMIT     = DEFAULT_MAX_PACKETS;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 2000;

    // Function code three is not a real code; the block treats it as out
    localparam logic [1:0] FUNC_ALIAS_OUT = 2'd3;

    typedef struct {
        logic [1:0]        func;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
        logic              want_empty;
        logic              handshake;
    } txn_t;

    typedef struct {
        logic [PID_W-1:0]  pid;
        logic              toggle;
        logic [LEN_W-1:0]  bytes;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic              too_long;
    } pkt_t;

    logic                aclk                = 1'b0;
    logic                aresetn             = 1'b0;
    logic                psel                = 1'b0;
    logic                penable             = 1'b0;
    logic                pwrite              = 1'b0;
    logic [2:0]          paddr               = '0;
    logic [31:0]         pwdata              = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid             = 1'b0;
    logic                s_ready;
    logic [1:0]          s_func              = '0;
    logic [LEN_W-1:0]    s_byte_length       = '0;
    logic [ADDR_W-1:0]   s_base_address      = '0;
    logic                s_want_empty_packet = 1'b0;
    logic                s_force_toggle_one  = 1'b0;
    logic                m_valid;
    logic                m_ready             = 1'b0;
    logic [PID_W-1:0]    m_packet_id;
    logic                m_data_toggle;
    logic [LEN_W-1:0]    m_packet_bytes;
    logic [ADDR_W-1:0]   m_packet_address;
    logic                m_final_packet;
    logic                m_too_long;

    // Shadow of the block's registers and toggle state
    logic [MPS_W-1:0]    mps_setting  = MPS_RESET;
    logic [KIND_W-1:0]   kind_setting = KIND_CONTROL;
    logic                toggle_state = 1'b0;

    pkt_t pending_packets[$];
    int   err_count       = 0;
    int   quiet_cycles    = 0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;

    usb_transaction_packet_splitter #(
        .MAX_PACKETS(PKT_LIMIT)
    ) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_byte_length       (s_byte_length),
        .s_base_address      (s_base_address),
        .s_want_empty_packet (s_want_empty_packet),
        .s_force_toggle_one  (s_force_toggle_one),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_packet_id         (m_packet_id),
        .m_data_toggle       (m_data_toggle),
        .m_packet_bytes      (m_packet_bytes),
        .m_packet_address    (m_packet_address),
        .m_final_packet      (m_final_packet),
        .m_too_long          (m_too_long)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Work out the packet descriptors of one accepted transaction
    function automatic void split_transaction(input txn_t t);
        logic [PID_W-1:0] pid;
        logic             setup_txn;
        logic             iso;
        logic             add_empty;
        logic             tog;
        int unsigned      mps;
        int unsigned      ndata;
        int unsigned      total;
        int unsigned      remaining;
        int unsigned      offset;
        int unsigned      step;
        pkt_t             p;
        setup_txn = (t.func == PID_SETUP);
        pid = setup_txn ? PID_SETUP : (t.func == PID_IN) ? PID_IN : PID_OUT;
        iso = (kind_setting == KIND_ISO);
        mps = (mps_setting == '0) ? 1 : mps_setting;
        remaining = t.len;
        if (setup_txn) begin
            ndata = (t.len != 0) ? 1 : 0;
        end else begin
            ndata = (remaining + mps - 1) / mps;
        end
        add_empty = t.want_empty || (kind_setting == KIND_BULK && pid == PID_OUT &&
                                     t.len != 0 && (remaining % mps) == 0);
        total = ndata + (add_empty ? 1 : 0);
        if (total == 0) begin
            return;
        end
        if (ndata > PKT_LIMIT - 1) begin
            // single error beat, toggle state left alone
            p.pid      = pid;
            p.toggle   = 1'b0;
            p.bytes    = '0;
            p.addr     = t.base;
            p.last     = 1'b1;
            p.too_long = 1'b1;
            pending_packets.push_back(p);
            return;
        end
        if (t.handshake && !iso) begin
            toggle_state = 1'b1;
        end
        offset = 0;
        for (int unsigned k = 0; k < total; k++) begin
            if (k >= ndata) begin
                step = 0;
            end else if (setup_txn) begin
                step = remaining;
            end else begin
                step = (remaining < mps) ? remaining : mps;
            end
            tog = (setup_txn || iso) ? 1'b0 : toggle_state;
            p.pid      = pid;
            p.toggle   = tog;
            p.bytes    = LEN_W'(step);
            p.addr     = t.base + ADDR_W'(offset);
            p.last     = (k + 1 == total);
            p.too_long = 1'b0;
            pending_packets.push_back(p);
            if (!iso) begin
                toggle_state = ~tog;
            end
            remaining -= step;
            offset    += step;
        end
    endfunction

    function automatic txn_t build_txn(input logic [1:0] func, input int unsigned len,
                                       input logic [ADDR_W-1:0] base,
                                       input logic want_empty, input logic handshake);
        txn_t t;
        t.func       = func;
        t.len        = LEN_W'(len);
        t.base       = base;
        t.want_empty = want_empty;
        t.handshake  = handshake;
        return t;
    endfunction

    // Lengths cluster round multiples of the packet size to hit the boundaries
    function automatic txn_t random_txn();
        txn_t        t;
        int unsigned mps;
        int unsigned kmax;
        int unsigned k;
        mps  = (mps_setting == '0) ? 1 : mps_setting;
        kmax = 4095 / mps;
        if (kmax > 66 && $urandom_range(3) != 0) begin
            kmax = 66;
        end
        k = $urandom_range(kmax, 1);
        case ($urandom_range(9))
            0, 1:    t.func = PID_SETUP;
            2, 3, 4: t.func = PID_IN;
            9:       t.func = FUNC_ALIAS_OUT;
            default: t.func = PID_OUT;
        endcase
        case ($urandom_range(5))
            0:       t.len = '0;
            1:       t.len = LEN_W'(k * mps);
            2:       t.len = LEN_W'(k * mps - 1);
            3:       t.len = LEN_W'(k * mps + 1);
            default: t.len = LEN_W'($urandom_range(4095));
        endcase
        t.base       = $urandom();
        t.want_empty = ($urandom_range(3) == 0);
        t.handshake  = ($urandom_range(3) == 0);
        return t;
    endfunction

    task automatic offer_transaction(input txn_t t);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_func              <= t.func;
        s_byte_length       <= t.len;
        s_base_address      <= t.base;
        s_want_empty_packet <= t.want_empty;
        s_force_toggle_one  <= t.handshake;
        do @(posedge aclk); while (!s_ready);
        split_transaction(t);
    endtask

    // Drop valid, let every expected beat arrive, then let the front end settle
    task automatic wait_for_idle(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_MPS) begin
            mps_setting = value[MPS_W-1:0];
        end else begin
            kind_setting = value[KIND_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic set_mode(input int unsigned mps, input logic [KIND_W-1:0] kind);
        wait_for_idle(SETTLE_CYCLES);
        write_reg(REG_MPS, 32'(mps));
        write_reg(REG_KIND, 32'(kind));
    endtask

    task automatic test_reset_settings();
        sender_idle_pct = 30;
        recv_stall_pct  = 30;
        offer_transaction(build_txn(PID_SETUP, 8, 32'h0000_0000, 1'b0, 1'b0));
        offer_transaction(build_txn(PID_IN, 200, 32'hFFFF_FFF0, 1'b0, 1'b0));
        // nothing to send, handshake request must not touch the toggle
        offer_transaction(build_txn(PID_OUT, 0, 32'h1234_5678, 1'b0, 1'b1));
        offer_transaction(build_txn(PID_SETUP, 0, 32'h0000_0100, 1'b0, 1'b1));
        offer_transaction(build_txn(PID_OUT, 0, 32'h0000_0200, 1'b1, 1'b0));
        offer_transaction(build_txn(PID_SETUP, 16, 32'h0000_0300, 1'b1, 1'b0));
        offer_transaction(build_txn(PID_IN, 4032, 32'h8000_0000, 1'b0, 1'b1));
        offer_transaction(build_txn(PID_IN, 4033, 32'h8000_0000, 1'b0, 1'b0));
        offer_transaction(build_txn(PID_OUT, 4095, 32'hFFFF_FFFF, 1'b1, 1'b1));
        offer_transaction(build_txn(FUNC_ALIAS_OUT, 100, 32'h0000_1000, 1'b0, 1'b0));
        // hold off until the block has emptied
        wait_for_idle(0);
    endtask

    task automatic test_packet_size_extremes();
        set_mode(0, KIND_CONTROL);
        offer_transaction(build_txn(PID_IN, 3, 32'h0000_0040, 1'b0, 1'b0));
        offer_transaction(build_txn(PID_OUT, 63, 32'h0000_0080, 1'b0, 1'b0));
        offer_transaction(build_txn(PID_OUT, 64, 32'h0000_00C0, 1'b0, 1'b0));
        set_mode(1023, KIND_INTR);
        offer_transaction(build_txn(PID_IN, 4095, 32'hFFFF_F000, 1'b0, 1'b1));
        offer_transaction(build_txn(PID_OUT, 1023, 32'h0000_2000, 1'b1, 1'b0));
    endtask

    task automatic test_transfer_kinds();
        set_mode(8, KIND_BULK);
        offer_transaction(build_txn(PID_OUT, 16, 32'h0000_3000, 1'b0, 1'b0));
        // trailing empty packet is never doubled
        offer_transaction(build_txn(PID_OUT, 16, 32'h0000_3100, 1'b1, 1'b0));
        offer_transaction(build_txn(PID_IN, 16, 32'h0000_3200, 1'b0, 1'b0));
        offer_transaction(build_txn(PID_OUT, 0, 32'h0000_3300, 1'b0, 1'b0));
        set_mode(8, KIND_ISO);
        offer_transaction(build_txn(PID_OUT, 20, 32'h0000_4000, 1'b0, 1'b1));
        offer_transaction(build_txn(PID_SETUP, 5, 32'h0000_4100, 1'b1, 1'b0));
    endtask

    task automatic test_random_traffic();
        int unsigned mps;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                case ($urandom_range(5))
                    0:       mps = $urandom_range(4, 1);
                    1:       mps = $urandom_range(70, 5);
                    2:       mps = 64;
                    3:       mps = 1023;
                    4:       mps = 0;
                    default: mps = $urandom_range(1023);
                endcase
                set_mode(mps, KIND_W'($urandom_range(3)));
                repeat (14) offer_transaction(random_txn());
            end
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_packets
        pkt_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_packets.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual pid %0d bytes %0d addr %h",
                         $time, m_packet_id, m_packet_bytes, m_packet_address);
                err_count++;
            end else begin
                want = pending_packets.pop_front();
                compare_field("packet_id", 32'(want.pid), 32'(m_packet_id));
                compare_field("data_toggle", 32'(want.toggle), 32'(m_data_toggle));
                compare_field("packet_bytes", 32'(want.bytes), 32'(m_packet_bytes));
                compare_field("packet_address", want.addr, m_packet_address);
                compare_field("final_packet", 32'(want.last), 32'(m_final_packet));
                compare_field("too_long", 32'(want.too_long), 32'(m_too_long));
            end
        end
    end

    // Stop a hung run: count cycles in which no transaction, no beat and no register access moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_packet_size_extremes();
        test_transfer_kinds();
        test_random_traffic();
        wait_for_idle(SETTLE_CYCLES);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: usb_transaction_packet_splitter.f
design/utps_pkg.sv
design/utps_front.sv
design/utps_queue.sv
design/utps_back.sv
design/usb_transaction_packet_splitter.sv
verif/usb_transaction_packet_splitter_test.sv
